@@ hw/rtl/ggh_pkg.sv @@
// ----------------------------------------------------------------------------
// ggh_pkg: shared definitions for the gradient/Hessian stencil
// Grid limits, window geometry, stencil tap table, register indexes, types.
// ----------------------------------------------------------------------------
package ggh_pkg;

   localparam int MAX_X      = 256;
   localparam int MAX_Y      = 256;
   localparam int DATA_WIDTH = 32;
   localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

   // window depth: two planes, two rows and one point
   localparam int WIN  = 2 * MAX_X * MAX_Y + 2 * MAX_X + 1;
   localparam int AW   = $clog2(WIN);
   localparam int SXW  = $clog2(MAX_X + 1);
   localparam int SYW  = $clog2(MAX_Y + 1);
   localparam int DZW  = SXW + SYW;
   localparam int PXW  = $clog2(MAX_X);
   localparam int PYW  = $clog2(MAX_Y);
   localparam int PZW  = 16;

   localparam int NSAMP = 19;
   localparam int TAGW  = $clog2(NSAMP);
   localparam int NUMW  = 36;
   localparam int NRES  = 9;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_GHOST  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_INV_X  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_INV_Y  = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_INV_Z  = 3'd6;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [1:0] OZ = 2'b00;
   localparam logic [1:0] OP = 2'b01;
   localparam logic [1:0] OM = 2'b11;

   typedef struct packed {
      logic signed [1:0] ex;
      logic signed [1:0] ey;
      logic signed [1:0] ez;
   } ggh_ofs_type;

   typedef struct packed {
      logic              vld;
      logic [TAGW-1:0]   tag;
   } ggh_samp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } ggh_inv_type;

   // first member in the top bits: d_dx lands in bits 31:0
   typedef struct packed {
      logic [31:0] d2_yz;
      logic [31:0] d2_xz;
      logic [31:0] d2_xy;
      logic [31:0] d2_zz;
      logic [31:0] d2_yy;
      logic [31:0] d2_xx;
      logic [31:0] d_dz;
      logic [31:0] d_dy;
      logic [31:0] d_dx;
   } ggh_res_type;

   // stencil taps relative to the center, read order; tap 0 is the center
   function automatic ggh_ofs_type ggh_offset(input logic [TAGW-1:0] idx);
      ggh_ofs_type o;
      case (idx)
         5'd0:    o = ggh_ofs_type'({OZ, OZ, OZ});
         5'd1:    o = ggh_ofs_type'({OP, OZ, OZ});
         5'd2:    o = ggh_ofs_type'({OM, OZ, OZ});
         5'd3:    o = ggh_ofs_type'({OZ, OP, OZ});
         5'd4:    o = ggh_ofs_type'({OZ, OM, OZ});
         5'd5:    o = ggh_ofs_type'({OZ, OZ, OP});
         5'd6:    o = ggh_ofs_type'({OZ, OZ, OM});
         5'd7:    o = ggh_ofs_type'({OP, OP, OZ});
         5'd8:    o = ggh_ofs_type'({OP, OM, OZ});
         5'd9:    o = ggh_ofs_type'({OM, OP, OZ});
         5'd10:   o = ggh_ofs_type'({OM, OM, OZ});
         5'd11:   o = ggh_ofs_type'({OP, OZ, OP});
         5'd12:   o = ggh_ofs_type'({OP, OZ, OM});
         5'd13:   o = ggh_ofs_type'({OM, OZ, OP});
         5'd14:   o = ggh_ofs_type'({OM, OZ, OM});
         5'd15:   o = ggh_ofs_type'({OZ, OP, OP});
         5'd16:   o = ggh_ofs_type'({OZ, OP, OM});
         5'd17:   o = ggh_ofs_type'({OZ, OM, OP});
         5'd18:   o = ggh_ofs_type'({OZ, OM, OM});
         default: o = ggh_ofs_type'({OZ, OZ, OZ});
      endcase
      return o;
   endfunction

endpackage

@@ hw/rtl/grid_gradient_hessian_stencil.sv @@
// ----------------------------------------------------------------------------
// grid_gradient_hessian_stencil: gradient and Hessian of a 3-component field
// Window memory, tap address sequencer, three component lanes and a merger.
// ----------------------------------------------------------------------------
// Usage:
//  req_*: one grid point per word in raster order (x fastest), three signed
//   Q16.16 components. A point outside the interior does not leave the idle state.
//  rsp_*: for each interior center three words (component in tuser: x, y, z),
//   tlast on the z word. A center is reported when the point one row and one
//   plane beyond it arrives.
//  csr_*: write-only registers, to be written while the block is idle, which
//   the block does not enforce; a geometry write restarts the frame position.
//  Flow: for an interior point the 19 stencil taps are read in turn on the
//   single memory read port, then each lane scales its 9 numerators on its
//   32x32 digit multiplier, and the results are loaded into the output buffer.
//   req_tready returns once the results are buffered, so the next point is taken
//   while the three result words wait on a stalled receiver.
//  Reset: position, registers and control are reset at once; the window memory
//   is not cleared, only entries of the current frame are ever read.
// ----------------------------------------------------------------------------
module grid_gradient_hessian_stencil import ggh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [95:0]        req_tdata,  // value_x, value_y, value_z
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [287:0]       rsp_tdata,  // d_dx, d_dy, d_dz, d2_xx, d2_yy, d2_zz, d2_xy, d2_xz, d2_yz
   output logic [1:0]         rsp_tuser,  // component
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [CSR_DW-1:0]  csr_wdata
);

   localparam int CW = 17;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_CALC  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [TAGW-1:0]  rd_idx_ff;
   logic [AW-1:0]    wp_ff;
   logic [AW-1:0]    cwp_ff;
   logic [PXW-1:0]   pos_x_ff;
   logic [PYW-1:0]   pos_y_ff;
   logic [PZW-1:0]   pos_z_ff;
   logic [8:0]       size_x_ff;
   logic [8:0]       size_y_ff;
   logic [15:0]      size_z_ff;
   logic [3:0]       ghost_ff;
   ggh_inv_type      inv_ff;
   logic [DZW-1:0]   dz_ff;
   ggh_samp_type     samp_ff;
   logic [95:0]      rdata_ff;
   logic [95:0]      mem [WIN];

   logic [SXW-1:0]   sx_eff;
   logic [SYW-1:0]   sy_eff;
   logic [15:0]      sz_eff;
   logic [3:0]       g_eff;
   logic [CW-1:0]    cx, cy, cz, gw, sxw, syw, szw;
   logic             interior;
   logic             req_acc;
   logic             geo_wr;
   ggh_ofs_type      ofs;
   logic [AW:0]      ky, kz, kv, diff;
   logic [AW-1:0]    rd_addr;
   logic [2:0]       lane_busy;
   ggh_res_type      lane_res [3];
   logic             lane_start;
   logic             mrg_load;
   logic             mrg_free;

   assign sx_eff = (size_x_ff < 9'd3) ? SXW'(3) :
                   ((32'(size_x_ff) > MAX_X) ? SXW'(MAX_X) : SXW'(size_x_ff));
   assign sy_eff = (size_y_ff < 9'd3) ? SYW'(3) :
                   ((32'(size_y_ff) > MAX_Y) ? SYW'(MAX_Y) : SYW'(size_y_ff));
   assign sz_eff = (size_z_ff < 16'd3) ? 16'd3 : size_z_ff;
   assign g_eff  = (ghost_ff == 4'd0) ? 4'd1 : ghost_ff;

   // center sits one row and one plane behind the arriving point
   assign cx  = CW'(pos_x_ff);
   assign cy  = CW'(pos_y_ff) - CW'(1);
   assign cz  = CW'(pos_z_ff) - CW'(1);
   assign gw  = CW'(g_eff);
   assign sxw = CW'(sx_eff);
   assign syw = CW'(sy_eff);
   assign szw = CW'(sz_eff);
   assign interior = (pos_y_ff != '0) && (pos_z_ff != '0) &&
                     (cx >= gw) && (cx + gw < sxw) &&
                     (cy >= gw) && (cy + gw < syw) &&
                     (cz >= gw) && (cz + gw < szw);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign geo_wr     = csr_we && (csr_addr == CSR_SIZE_X || csr_addr == CSR_SIZE_Y ||
                                  csr_addr == CSR_SIZE_Z || csr_addr == CSR_GHOST);

   // tap address: newest point minus ((1-ey)dy + (1-ez)dz - ex), wrapped
   assign ofs = ggh_offset(rd_idx_ff);
   always_comb begin
      if (ofs.ey == 2'sd0) ky = (AW+1)'(sx_eff);
      else if (ofs.ey == -2'sd1) ky = (AW+1)'({sx_eff, 1'b0});
      else ky = '0;
      if (ofs.ez == 2'sd0) kz = (AW+1)'(dz_ff);
      else if (ofs.ez == -2'sd1) kz = (AW+1)'({dz_ff, 1'b0});
      else kz = '0;
      kv = ky + kz + (AW+1)'(ofs.ex == -2'sd1) - (AW+1)'(ofs.ex == 2'sd1);
      diff = {1'b0, cwp_ff} - kv;
      rd_addr = diff[AW] ? AW'(diff + (AW+1)'(WIN)) : diff[AW-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      lane_start = 1'b0;
      mrg_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (req_acc && interior) state_in = S_READ;
         S_READ:  if (rd_idx_ff == TAGW'(NSAMP - 1)) state_in = S_WAIT;
         S_WAIT:  state_in = S_START;
         S_START: begin
            lane_start = 1'b1;
            state_in   = S_CALC;
         end
         S_CALC: begin
            if (lane_busy == '0 && mrg_free) begin
               mrg_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_idx_ff <= '0;
         samp_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         samp_ff.vld <= (state_ff == S_READ);
         samp_ff.tag <= rd_idx_ff;
         if (state_ff == S_READ) rd_idx_ff <= rd_idx_ff + TAGW'(1);
         else rd_idx_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      dz_ff <= DZW'(sx_eff * sy_eff);
      if (req_acc) begin
         mem[wp_ff] <= req_tdata;
      end
      if (state_ff == S_READ) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         cwp_ff    <= '0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         size_x_ff <= 9'd256;
         size_y_ff <= 9'd256;
         size_z_ff <= 16'd256;
         ghost_ff  <= 4'd1;
         inv_ff    <= '{x: 32'd65536, y: 32'd65536, z: 32'd65536};
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SIZE_X: size_x_ff <= csr_wdata[8:0];
               CSR_SIZE_Y: size_y_ff <= csr_wdata[8:0];
               CSR_SIZE_Z: size_z_ff <= csr_wdata[15:0];
               CSR_GHOST:  ghost_ff  <= csr_wdata[3:0];
               CSR_INV_X:  inv_ff.x  <= csr_wdata;
               CSR_INV_Y:  inv_ff.y  <= csr_wdata;
               CSR_INV_Z:  inv_ff.z  <= csr_wdata;
               default:    ;
            endcase
         end
         if (req_acc) begin
            cwp_ff <= wp_ff;
            wp_ff  <= (wp_ff == AW'(WIN - 1)) ? '0 : wp_ff + AW'(1);
         end
         if (geo_wr) begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            pos_z_ff <= '0;
         end else if (req_acc) begin
            if (cx + CW'(1) >= sxw) begin
               pos_x_ff <= '0;
               if (CW'(pos_y_ff) + CW'(1) >= syw) begin
                  pos_y_ff <= '0;
                  pos_z_ff <= (CW'(pos_z_ff) + CW'(1) >= szw) ? '0 : pos_z_ff + 16'd1;
               end else begin
                  pos_y_ff <= pos_y_ff + PYW'(1);
               end
            end else begin
               pos_x_ff <= pos_x_ff + PXW'(1);
            end
         end
      end
   end

   for (genvar n = 0; n < 3; n++) begin : g_lane
      ggh_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .samp      (samp_ff),
         .samp_data (rdata_ff[32*n +: 32]),
         .start     (lane_start),
         .inv       (inv_ff),
         .busy      (lane_busy[n]),
         .res       (lane_res[n])
      );
   end

   ggh_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (mrg_load),
      .res_x      (lane_res[0]),
      .res_y      (lane_res[1]),
      .res_z      (lane_res[2]),
      .free       (mrg_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_last_is_z: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == COMP_Z)
      else $error("tlast on a word other than component z");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      mrg_load |-> mrg_free)
      else $error("result buffer loaded while still holding words");

   a_idle_lanes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> lane_busy == '0)
      else $error("lane busy while sequencer is idle");

   a_tap_window: assert property (@(posedge clock) disable iff (reset)
      samp_ff.vld |-> state_ff == S_READ || state_ff == S_WAIT)
      else $error("tap word outside the read window");
`endif

endmodule

@@ hw/rtl/ggh_lane.sv @@
// ----------------------------------------------------------------------------
// ggh_lane: one field component
// Accumulates the nine stencil numerators from the tap stream, then scales
// each by the reciprocal spacings on a 32x32 digit multiplier and saturates.
// ----------------------------------------------------------------------------
module ggh_lane import ggh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ggh_samp_type samp,
   input  logic [31:0]  samp_data,
   input  logic         start,
   input  ggh_inv_type  inv,
   output logic         busy,
   output ggh_res_type  res
);

   localparam int OPW  = 96;
   localparam int MACW = 128;

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_LOAD = 2'd1;
   localparam logic [1:0] L_MUL  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;

   logic [1:0]             state_ff;
   logic [3:0]             j_ff;
   logic [1:0]             dig_ff;
   logic [1:0]             dlast_ff;
   logic                   ph2_ff;
   logic                   neg_ff;
   logic [31:0]            m_ff;
   logic [OPW-1:0]         op_ff;
   logic [MACW-1:0]        mac_ff;
   logic signed [NUMW-1:0] num_ff [NRES];
   logic [31:0]            res_ff [NRES];

   logic signed [NUMW-1:0] s_ext;
   ggh_ofs_type            ofs;
   logic signed [NUMW-1:0] num_sel;
   logic [NUMW-1:0]        mag;
   logic [63:0]            prod;
   logic [MACW-1:0]        pacc;
   logic [MACW-1:0]        q;
   logic [MACW-1:0]        qc;
   logic [MACW-1:0]        sat;
   logic [MACW-1:0]        half;
   logic                   rb;
   logic [6:0]             sh;

   // contribution of one tap to numerator i
   function automatic logic signed [NUMW-1:0] lane_contrib(
      input logic [3:0] i, input ggh_ofs_type o, input logic signed [NUMW-1:0] s);
      logic signed [1:0]      ea;
      logic signed [1:0]      eb;
      logic signed [1:0]      ec;
      logic signed [NUMW-1:0] r;
      r = '0;
      case (i) inside
         4'd0, 4'd3: begin ea = o.ex; eb = o.ey; ec = o.ez; end
         4'd1, 4'd4: begin ea = o.ey; eb = o.ex; ec = o.ez; end
         4'd2, 4'd5: begin ea = o.ez; eb = o.ex; ec = o.ey; end
         4'd6:       begin ea = o.ex; eb = o.ey; ec = o.ez; end
         4'd7:       begin ea = o.ex; eb = o.ez; ec = o.ey; end
         default:    begin ea = o.ey; eb = o.ez; ec = o.ex; end
      endcase
      if (i < 4'd3) begin
         if (eb == 2'sd0 && ec == 2'sd0) begin
            if (ea == 2'sd1) r = s;
            else if (ea == -2'sd1) r = -s;
         end
      end else if (i < 4'd6) begin
         if (eb == 2'sd0 && ec == 2'sd0) r = (ea == 2'sd0) ? -(s <<< 1) : s;
      end else begin
         if (ec == 2'sd0 && ea != 2'sd0 && eb != 2'sd0) r = (ea == eb) ? s : -s;
      end
      return r;
   endfunction

   function automatic logic [31:0] lane_m1(input logic [3:0] j, input ggh_inv_type v);
      logic [31:0] m;
      case (j) inside
         4'd0, 4'd3, 4'd6, 4'd7: m = v.x;
         4'd1, 4'd4, 4'd8:       m = v.y;
         default:                m = v.z;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] lane_m2(input logic [3:0] j, input ggh_inv_type v);
      logic [31:0] m;
      case (j) inside
         4'd3:                   m = v.x;
         4'd4, 4'd6:             m = v.y;
         default:                m = v.z;
      endcase
      return m;
   endfunction

   assign s_ext   = {{(NUMW-32){samp_data[31]}}, samp_data};
   assign ofs     = ggh_offset(samp.tag);
   assign num_sel = num_ff[j_ff];
   assign mag     = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
   assign prod    = op_ff[{dig_ff, 5'b0} +: 32] * m_ff;
   assign pacc    = mac_ff + (MACW'(prod) << {dig_ff, 5'b0});
   assign half    = MACW'(1) << (SAT_BITS - 1);

   always_comb begin
      if (j_ff < 4'd3) sh = 7'd17;
      else if (j_ff < 4'd6) sh = 7'd32;
      else sh = 7'd34;
      q  = mac_ff >> sh;
      // floor of a negative quotient: round the magnitude up
      rb = neg_ff & (|(mac_ff & ~({MACW{1'b1}} << sh)));
      qc = q + MACW'(rb);
      if (!neg_ff) sat = (qc > half - 1) ? half - 1 : qc;
      else sat = (qc > half) ? -half : -qc;
   end

   always_ff @(posedge clock) begin
      if (samp.vld) begin
         for (int i = 0; i < NRES; i++) begin
            num_ff[i] <= ((samp.tag == '0) ? '0 : num_ff[i]) + lane_contrib(4'(i), ofs, s_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  state_ff <= L_LOAD;
                  j_ff     <= '0;
               end
            end
            L_LOAD: begin
               neg_ff   <= num_sel[NUMW-1];
               op_ff    <= OPW'(mag);
               m_ff     <= lane_m1(j_ff, inv);
               mac_ff   <= '0;
               dig_ff   <= '0;
               dlast_ff <= 2'd1;
               ph2_ff   <= 1'b0;
               state_ff <= L_MUL;
            end
            L_MUL: begin
               if (dig_ff == dlast_ff) begin
                  if (!ph2_ff && j_ff >= 4'd3) begin
                     op_ff    <= pacc[OPW-1:0];
                     m_ff     <= lane_m2(j_ff, inv);
                     mac_ff   <= '0;
                     dig_ff   <= '0;
                     dlast_ff <= 2'd2;
                     ph2_ff   <= 1'b1;
                  end else begin
                     mac_ff   <= pacc;
                     state_ff <= L_FIN;
                  end
               end else begin
                  mac_ff <= pacc;
                  dig_ff <= dig_ff + 2'd1;
               end
            end
            L_FIN: begin
               res_ff[j_ff] <= sat[31:0];
               if (j_ff == 4'(NRES - 1)) begin
                  state_ff <= L_IDLE;
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  state_ff <= L_LOAD;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != L_IDLE);
   assign res.d_dx  = res_ff[0];
   assign res.d_dy  = res_ff[1];
   assign res.d_dz  = res_ff[2];
   assign res.d2_xx = res_ff[3];
   assign res.d2_yy = res_ff[4];
   assign res.d2_zz = res_ff[5];
   assign res.d2_xy = res_ff[6];
   assign res.d2_xz = res_ff[7];
   assign res.d2_yz = res_ff[8];

endmodule

@@ hw/rtl/ggh_merge.sv @@
// ----------------------------------------------------------------------------
// ggh_merge: result serializer
// Holds the three lanes' results of one point and sends them as x, y, z words.
// ----------------------------------------------------------------------------
module ggh_merge import ggh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  ggh_res_type  res_x,
   input  ggh_res_type  res_y,
   input  ggh_res_type  res_z,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,  // d_dx, d_dy, d_dz, d2_xx, d2_yy, d2_zz, d2_xy, d2_xz, d2_yz
   output logic [1:0]   rsp_tuser,  // component
   output logic         rsp_tlast
);

   ggh_res_type buf_ff [3];
   logic [1:0]  cnt_ff;
   logic        full_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff[0] <= res_x;
         buf_ff[1] <= res_y;
         buf_ff[2] <= res_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         cnt_ff  <= COMP_X;
      end else if (load) begin
         full_ff <= 1'b1;
         cnt_ff  <= COMP_X;
      end else if (full_ff && rsp_tready) begin
         if (cnt_ff == COMP_Z) begin
            full_ff <= 1'b0;
            cnt_ff  <= COMP_X;
         end else begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end
   end

   assign free       = !full_ff;
   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = buf_ff[cnt_ff];
   assign rsp_tuser  = cnt_ff;
   assign rsp_tlast  = (cnt_ff == COMP_Z);

endmodule

@@ dv/grid_gradient_hessian_stencil_tb.sv @@
// ----------------------------------------------------------------------------
// grid_gradient_hessian_stencil_tb: self-checking bench for the 3D stencil
// Streams grid points under several geometries and spacings, predicts the
// gradient/Hessian words of each interior center and checks every result
// word in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module grid_gradient_hessian_stencil_tb;
   import ggh_pkg::*;

   localparam logic [CSR_AW-1:0] CSR_UNUSED = 3'd7;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int RANDOM_POINTS = 160;

   typedef struct {
      logic [1:0]  comp;
      logic [31:0] f[9];
      logic        last;
   } deriv_word_t;

   // keeps a copy of the geometry and spacings, the current frame and the pending words
   class deriv_scoreboard;
      logic [31:0] frame_x[int];
      logic [31:0] frame_y[int];
      logic [31:0] frame_z[int];
      deriv_word_t pending[$];
      int px, py, pz;
      logic [8:0]  size_x, size_y;
      logic [15:0] size_z;
      logic [3:0]  ghost;
      logic [31:0] inv_x, inv_y, inv_z;
      int errors, centers, points;

      function new();
         size_x = 256; size_y = 256; size_z = 256; ghost = 1;
         inv_x = 32'h10000; inv_y = 32'h10000; inv_z = 32'h10000;
         px = 0; py = 0; pz = 0; errors = 0; centers = 0; points = 0;
      endfunction

      function void write_reg(logic [CSR_AW-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_SIZE_X: size_x = v[8:0];
            CSR_SIZE_Y: size_y = v[8:0];
            CSR_SIZE_Z: size_z = v[15:0];
            CSR_GHOST:  ghost  = v[3:0];
            CSR_INV_X:  inv_x  = v;
            CSR_INV_Y:  inv_y  = v;
            CSR_INV_Z:  inv_z  = v;
            default: ;
         endcase
         if (idx inside {CSR_SIZE_X, CSR_SIZE_Y, CSR_SIZE_Z, CSR_GHOST}) begin
            px = 0; py = 0; pz = 0;
         end
      endfunction

      // floor(num * m1 * m2 / 2^sh), saturated to 32 bits
      function logic [31:0] scale_sat(longint num, logic [31:0] m1, logic [31:0] m2,
                                      int sh);
         logic signed [127:0] p;
         p = num;
         p = p * $signed({96'd0, m1});
         p = p * $signed({96'd0, m2});
         p = p >>> sh;
         if (p > 128'sd2147483647) return 32'h7fffffff;
         if (p < -(128'sd2147483648)) return 32'h80000000;
         return p[31:0];
      endfunction

      function longint tap(int n, int a);
         logic [31:0] v;
         v = (n == 0) ? frame_x[a] : ((n == 1) ? frame_y[a] : frame_z[a]);
         return longint'($signed(v));
      endfunction

      function void note_input(logic [95:0] d);
         int sx, sy, sz, g, dy, dz, idx, c, cx, cy, cz;
         longint f0, xp, xm, yp, ym, zp, zm, xy, xz, yz;
         deriv_word_t w;
         sx = (size_x < 3) ? 3 : ((size_x > MAX_X) ? MAX_X : size_x);
         sy = (size_y < 3) ? 3 : ((size_y > MAX_Y) ? MAX_Y : size_y);
         sz = (size_z < 3) ? 3 : size_z;
         g  = (ghost == 0) ? 1 : ghost;
         dy = sx; dz = sx * sy;
         idx = px + py * dy + pz * dz;
         frame_x[idx] = d[31:0];
         frame_y[idx] = d[63:32];
         frame_z[idx] = d[95:64];
         points++;
         if (py >= 1 && pz >= 1) begin
            cx = px; cy = py - 1; cz = pz - 1;
            if (cx >= g && cx + g < sx && cy >= g && cy + g < sy &&
                cz >= g && cz + g < sz) begin
               c = idx - dy - dz;
               centers++;
               for (int n = 0; n < 3; n++) begin
                  f0 = tap(n, c);
                  xp = tap(n, c + 1);  xm = tap(n, c - 1);
                  yp = tap(n, c + dy); ym = tap(n, c - dy);
                  zp = tap(n, c + dz); zm = tap(n, c - dz);
                  xy = tap(n, c+1+dy) - tap(n, c+1-dy) - tap(n, c-1+dy) + tap(n, c-1-dy);
                  xz = tap(n, c+1+dz) - tap(n, c+1-dz) - tap(n, c-1+dz) + tap(n, c-1-dz);
                  yz = tap(n, c+dy+dz) - tap(n, c+dy-dz) - tap(n, c-dy+dz)
                       + tap(n, c-dy-dz);
                  w.comp = (n == 0) ? COMP_X : ((n == 1) ? COMP_Y : COMP_Z);
                  w.f[0] = scale_sat(xp - xm, inv_x, 1, 17);
                  w.f[1] = scale_sat(yp - ym, inv_y, 1, 17);
                  w.f[2] = scale_sat(zp - zm, inv_z, 1, 17);
                  w.f[3] = scale_sat(xp - 2 * f0 + xm, inv_x, inv_x, 32);
                  w.f[4] = scale_sat(yp - 2 * f0 + ym, inv_y, inv_y, 32);
                  w.f[5] = scale_sat(zp - 2 * f0 + zm, inv_z, inv_z, 32);
                  w.f[6] = scale_sat(xy, inv_x, inv_y, 34);
                  w.f[7] = scale_sat(xz, inv_x, inv_z, 34);
                  w.f[8] = scale_sat(yz, inv_y, inv_z, 34);
                  w.last = (n == 2);
                  pending.push_back(w);
               end
            end
         end
         px++;
         if (px >= sx) begin
            px = 0; py++;
            if (py >= sy) begin
               py = 0; pz++;
               if (pz >= sz) pz = 0;
            end
         end
      endfunction

      function void check_word(logic [287:0] data, logic [1:0] comp, logic last);
         deriv_word_t w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word comp=%0d data=%h", $time, comp, data);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (comp !== w.comp) begin
            $display("%0t: component expected %0d actual %0d", $time, w.comp, comp);
            errors++;
         end
         if (last !== w.last) begin
            $display("%0t: tlast expected %0b actual %0b", $time, w.last, last);
            errors++;
         end
         for (int k = 0; k < 9; k++)
            if (data[32*k +: 32] !== w.f[k]) begin
               $display("%0t: comp %0d field %0d expected %h actual %h",
                        $time, w.comp, k, w.f[k], data[32*k +: 32]);
               errors++;
            end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [95:0]        req_tdata;   // value_x, value_y, value_z
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [287:0]       rsp_tdata;   // d_dx, d_dy, d_dz, d2_xx .. d2_zz, d2_xy, d2_xz, d2_yz
   logic [1:0]         rsp_tuser;   // component
   logic               rsp_tlast;
   logic               csr_we;
   logic [CSR_AW-1:0]  csr_addr;
   logic [CSR_DW-1:0]  csr_wdata;

   deriv_scoreboard sb;
   int cycles;
   int random_points;

   grid_gradient_hessian_stencil dut (.*);

   initial begin
      clock = 0; reset = 1;
      req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      csr_we = 0; csr_addr = '0; csr_wdata = '0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // no idling on either side during this stretch
   function automatic bit may_idle();
      return !(cycles >= 1500 && cycles < 3000) && $urandom_range(0, 99) < 10;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= reset ? 1'b0 : !may_idle();
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_point(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      while (may_idle()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input({c, b, a});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);   // a non-interior tail may still be in flight
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [31:0] v);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(int sx, int sy, int sz, int g, logic [31:0] ix,
                        logic [31:0] iy, logic [31:0] iz);
      drain();
      write_reg(CSR_SIZE_X, sx);
      write_reg(CSR_SIZE_Y, sy);
      write_reg(CSR_SIZE_Z, sz);
      write_reg(CSR_GHOST, g);
      write_reg(CSR_INV_X, ix);
      write_reg(CSR_INV_Y, iy);
      write_reg(CSR_INV_Z, iz);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 262143) - 131072;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_inv();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hffffffff;
         3: return 32'h10000;
         4: return $urandom_range(1, 32'h40000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_points(int n);
      for (int i = 0; i < n; i++)
         send_point(pick_value(), pick_value(), pick_value());
   endtask

   initial begin
      int sx, sy, sz, n;
      sb = new();
      cycles = 0;
      random_points = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: smallest grid, one interior center, extreme values
      write_reg(CSR_UNUSED, 32'hffffffff);
      setup(3, 3, 3, 1, 32'h10000, 32'h10000, 32'h10000);
      for (int i = 0; i < 27; i++)
         send_point((i % 2) ? 32'h7fffffff : 32'h80000000,
                    (i == 13) ? 32'h80000000 : 32'h7fffffff,
                    (i % 3 == 0) ? 32'h0 : 32'hffffffff);
      // saturation with the largest spacing reciprocals, then zero, tiny and largest reciprocals on sizes below 3
      setup(3, 3, 3, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_points(27);
      setup(0, 1, 2, 1, 32'd0, 32'd1, 32'hffffffff);
      send_points(27);
      // ghost width too wide for any interior point
      setup(5, 5, 5, 15, 32'h10000, 32'h10000, 32'h10000);
      send_points(25);

      // longest extent along z, then a ghost width of 8
      setup(3, 3, 65535, 1, pick_inv(), pick_inv(), pick_inv());
      send_points(60);
      setup(20, 20, 20, 8, 32'h10000, 32'h10000, 32'h10000);
      send_points(60);

      // random geometries, frames that wrap and frames cut short
      while (random_points < RANDOM_POINTS) begin
         sx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 7);
         sy = $urandom_range(3, 6);
         sz = $urandom_range(3, 5);
         setup(sx, sy, sz, $urandom_range(0, 2), pick_inv(), pick_inv(), pick_inv());
         if (sx < 3) sx = 3;
         n = sx * sy * sz;
         case ($urandom_range(0, 3))
            0: n = n + $urandom_range(1, n);
            1: n = $urandom_range(1, n);
            default: ;
         endcase
         if (n > RANDOM_POINTS - random_points) n = RANDOM_POINTS - random_points;
         send_points(n);
         random_points += n;
      end

      drain();
      $display("covered %0d points, %0d interior centers, %0d result words",
               sb.points, sb.centers, 3 * sb.centers);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
